// ===== rtl/graded_monomial_enumerator_macros.svh =====
// Assertion helpers included by the top-level RTL.
`ifndef GRADED_MONOMIAL_ENUMERATOR_MACROS_SVH
`define GRADED_MONOMIAL_ENUMERATOR_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define GME_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a request firing now leaves a condition true in the next cycle.
`define GME_ASSERT_NEXT(label, trig, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (prop)) \
    else $error(msg);

`endif

// ===== rtl/gme_pkg.sv =====
`default_nettype none

package gme_pkg;

  localparam int MAX_VARS_DEF   = 8;
  localparam int MAX_DEGREE_DEF = 15;

  localparam int EXP_W    = 32;
  localparam int DEG_W    = 4;
  localparam int IDX_W    = 19;
  localparam int NIB_W    = 4;
  localparam int NUM_PACK = EXP_W / NIB_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 4;

  localparam logic [CFG_DAT_W-1:0] NUM_VARS_RST   = 4'd8;
  localparam logic [CFG_DAT_W-1:0] MAX_DEGREE_RST = 4'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_VARS   = 2'd0,
    CFG_MAX_DEGREE = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [NIB_W-1:0] top;
    logic [DEG_W-1:0] maxd;
  } cfg_t;

  typedef struct packed {
    logic [DEG_W-1:0] cur_deg;
    logic             fresh;
    logic [IDX_W-1:0] idx;
    logic             fin;
  } state_t;

  typedef struct packed {
    logic [EXP_W-1:0] exponents;
    logic [DEG_W-1:0] total_degree;
    logic [IDX_W-1:0] mono_index;
    logic             last;
    logic             done_res;
  } result_t;

  function automatic int clog2_min1(int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/gme_cfg.sv =====
`default_nettype none

module gme_cfg #(
  parameter int MAX_VARS   = gme_pkg::MAX_VARS_DEF,
  parameter int MAX_DEGREE = gme_pkg::MAX_DEGREE_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             wr_i,
  input  wire logic [gme_pkg::CFG_IDX_W-1:0]    index_i,
  input  wire logic [gme_pkg::CFG_DAT_W-1:0]    data_i,
  output gme_pkg::cfg_t                         cfg_o
);
  import gme_pkg::*;

  logic [CFG_DAT_W-1:0] num_vars_q;
  logic [CFG_DAT_W-1:0] max_degree_q;
  logic [CFG_DAT_W:0]   n_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_vars_q   <= NUM_VARS_RST;
      max_degree_q <= MAX_DEGREE_RST;
    end else if (wr_i) begin
      if (index_i == CFG_NUM_VARS) begin
        num_vars_q <= data_i;
      end
      if (index_i == CFG_MAX_DEGREE) begin
        max_degree_q <= data_i;
      end
    end
  end

  always_comb begin
    if (num_vars_q == '0) begin
      n_eff = (CFG_DAT_W+1)'(1);
    end else if ({1'b0, num_vars_q} > (CFG_DAT_W+1)'(MAX_VARS)) begin
      n_eff = (CFG_DAT_W+1)'(MAX_VARS);
    end else begin
      n_eff = {1'b0, num_vars_q};
    end
    cfg_o.top = NIB_W'(n_eff - (CFG_DAT_W+1)'(1));
    if ({1'b0, max_degree_q} > (CFG_DAT_W+1)'(MAX_DEGREE)) begin
      cfg_o.maxd = DEG_W'(MAX_DEGREE);
    end else begin
      cfg_o.maxd = max_degree_q;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gme_step.sv =====
`default_nettype none

module gme_step #(
  parameter int MAX_VARS   = gme_pkg::MAX_VARS_DEF,
  parameter int MAX_DEGREE = gme_pkg::MAX_DEGREE_DEF
) (
  input  wire logic                                         restart_i,
  input  wire gme_pkg::cfg_t                                cfg_i,
  input  wire gme_pkg::state_t                              st_i,
  input  wire logic [gme_pkg::clog2_min1(MAX_VARS)-1:0]     pos_i [MAX_DEGREE],
  output gme_pkg::state_t                                   st_o,
  output logic [gme_pkg::clog2_min1(MAX_VARS)-1:0]          pos_o [MAX_DEGREE],
  output gme_pkg::result_t                                  res_o
);
  import gme_pkg::*;

  localparam int PW   = clog2_min1(MAX_VARS);
  localparam int NOUT = (MAX_VARS < NUM_PACK) ? MAX_VARS : NUM_PACK;

  logic             start;
  logic [DEG_W-1:0] cd;
  logic [DEG_W-1:0] cd_m1;
  logic [PW-1:0]    top_p;
  logic [PW-1:0]    clamped [MAX_DEGREE];
  logic [PW-1:0]    adv     [MAX_DEGREE];
  logic [PW-1:0]    last_p;
  logic             found;
  logic [DEG_W-1:0] jidx;
  logic [PW-1:0]    jval;
  logic             all_end;
  logic             is_last;
  logic [NIB_W-1:0] cnt [NOUT];
  logic [EXP_W-1:0] packed_exp;

  assign start = restart_i || ((st_i.idx == '0) && !st_i.fin);
  assign cd    = (st_i.cur_deg == '0) ? DEG_W'(1) : st_i.cur_deg;
  assign cd_m1 = cd - DEG_W'(1);
  assign top_p = PW'(cfg_i.top);

  // clamp, then find the rightmost position below the top variable
  always_comb begin
    last_p = '0;
    found  = 1'b0;
    jidx   = '0;
    jval   = '0;
    for (int k = 0; k < MAX_DEGREE; k++) begin
      if ((DEG_W'(k) < cd) && (NIB_W'(pos_i[k]) > cfg_i.top)) begin
        clamped[k] = top_p;
      end else begin
        clamped[k] = pos_i[k];
      end
      if (DEG_W'(k) == cd_m1) begin
        last_p = clamped[k];
      end
      if ((DEG_W'(k) < cd_m1) && (clamped[k] < top_p)) begin
        found = 1'b1;
        jidx  = DEG_W'(k);
        jval  = clamped[k];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < MAX_DEGREE; k++) begin
      if (st_i.fresh) begin
        adv[k] = (DEG_W'(k) < cd) ? '0 : pos_i[k];
      end else if (last_p == top_p) begin
        if (found && (DEG_W'(k) >= jidx) && (DEG_W'(k) < cd)) begin
          adv[k] = jval + PW'(1);
        end else begin
          adv[k] = clamped[k];
        end
      end else begin
        adv[k] = (DEG_W'(k) == cd_m1) ? last_p + PW'(1) : clamped[k];
      end
    end
  end

  always_comb begin
    all_end    = 1'b1;
    packed_exp = '0;
    for (int k = 0; k < MAX_DEGREE; k++) begin
      if ((DEG_W'(k) < cd) && (adv[k] != top_p)) begin
        all_end = 1'b0;
      end
    end
    for (int v = 0; v < NOUT; v++) begin
      cnt[v] = '0;
      for (int k = 0; k < MAX_DEGREE; k++) begin
        if ((DEG_W'(k) < cd) && (adv[k] == PW'(v))) begin
          cnt[v] = cnt[v] + NIB_W'(1);
        end
      end
      packed_exp[NIB_W*v +: NIB_W] = cnt[v];
    end
  end

  assign is_last = all_end && (cd >= cfg_i.maxd);

  always_comb begin
    st_o  = st_i;
    pos_o = pos_i;
    res_o = '0;
    if (start) begin
      res_o.last  = (cfg_i.maxd == '0);
      st_o.idx    = IDX_W'(1);
      st_o.fin    = (cfg_i.maxd == '0);
      st_o.cur_deg = (cfg_i.maxd == '0) ? '0 : DEG_W'(1);
      st_o.fresh  = 1'b1;
    end else if (st_i.fin) begin
      res_o.done_res = 1'b1;
    end else begin
      res_o.exponents    = packed_exp;
      res_o.total_degree = cd;
      res_o.mono_index   = st_i.idx;
      res_o.last         = is_last;
      pos_o              = adv;
      st_o.idx           = st_i.idx + IDX_W'(1);
      st_o.fin           = is_last;
      st_o.fresh         = all_end && !is_last;
      st_o.cur_deg       = (all_end && !is_last) ? cd + DEG_W'(1) : cd;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/graded_monomial_enumerator.sv =====
// Graded monomial enumerator: each request with restart set returns the constant monomial
// and starts a new run; each request with restart clear returns the next exponent vector
// in degree order, lexicographic within a degree, with its degree and running index, and
// last marks x_n^max_degree. Afterwards advances return done_res with all other fields zero
// until a restart. Throughput is one request per clock cycle unless out_stall_i holds the
// result register: the whole successor step (clamp, priority search over the stored degree
// positions, refill and per-variable counts) is combinational logic between the input
// register and the result register. No clearing pass follows reset.
// Write num_vars and max_degree only while no request is in flight.
`default_nettype none

module graded_monomial_enumerator #(
  parameter int MAX_VARS   = gme_pkg::MAX_VARS_DEF,
  parameter int MAX_DEGREE = gme_pkg::MAX_DEGREE_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic                              in_restart_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [gme_pkg::EXP_W-1:0]              out_exponents_o,
  output logic [gme_pkg::DEG_W-1:0]              out_total_degree_o,
  output logic [gme_pkg::IDX_W-1:0]              out_mono_index_o,
  output logic                                   out_last_o,
  output logic                                   out_done_res_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [gme_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [gme_pkg::CFG_DAT_W-1:0]     cfg_data_i
);
  import gme_pkg::*;

  localparam int PW = clog2_min1(MAX_VARS);

  cfg_t    cfg;
  state_t  st_q, st_d;
  result_t res_d, res_q;
  logic [PW-1:0] pos_q [MAX_DEGREE];
  logic [PW-1:0] pos_d [MAX_DEGREE];
  logic in_valid_q;
  logic restart_q;
  logic out_valid_q;
  logic advance;
  logic fire;

  assign cfg_ready_o = 1'b1;

  gme_cfg #(
    .MAX_VARS  (MAX_VARS),
    .MAX_DEGREE(MAX_DEGREE)
  ) u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (cfg_valid_i && cfg_ready_o),
    .index_i(cfg_index_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  gme_step #(
    .MAX_VARS  (MAX_VARS),
    .MAX_DEGREE(MAX_DEGREE)
  ) u_step (
    .restart_i(restart_q),
    .cfg_i    (cfg),
    .st_i     (st_q),
    .pos_i    (pos_q),
    .st_o     (st_d),
    .pos_o    (pos_d),
    .res_o    (res_d)
  );

  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      restart_q  <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
      restart_q  <= in_restart_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{cur_deg: '0, fresh: 1'b1, idx: '0, fin: 1'b0};
      for (int k = 0; k < MAX_DEGREE; k++) begin
        pos_q[k] <= '0;
      end
    end else if (fire) begin
      st_q  <= st_d;
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_exponents_o    = res_q.exponents;
  assign out_total_degree_o = res_q.total_degree;
  assign out_mono_index_o   = res_q.mono_index;
  assign out_last_o         = res_q.last;
  assign out_done_res_o     = res_q.done_res;

`include "graded_monomial_enumerator_macros.svh"

  `GME_ASSERT(a_done_zero, (out_valid_q && res_q.done_res) |-> ((res_q.exponents == '0) && (res_q.total_degree == '0) && (res_q.mono_index == '0) && !res_q.last), "done result carries nonzero fields")
  `GME_ASSERT_NEXT(a_last_sets_fin, fire && res_d.last, st_q.fin && out_valid_q && res_q.last, "last result did not finish the run")
  `GME_ASSERT_NEXT(a_fin_gives_done, fire && st_q.fin && !restart_q, res_q.done_res && st_q.fin, "advance after finish did not report done")
  `GME_ASSERT_NEXT(a_restart_index, fire && restart_q, (res_q.mono_index == '0) && (st_q.idx == IDX_W'(1)), "restart did not rewind the index")
  `GME_ASSERT(a_stall_cause, in_stall_o |-> (out_valid_q && out_stall_i && in_valid_q), "input stalled while the result path was free")

endmodule

`default_nettype wire

// ===== test/monomial_checker.sv =====
`timescale 1ns / 100ps

module monomial_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic                          in_restart_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [gme_pkg::EXP_W-1:0]     out_exponents_i,
  input  logic [gme_pkg::DEG_W-1:0]     out_total_degree_i,
  input  logic [gme_pkg::IDX_W-1:0]     out_mono_index_i,
  input  logic                          out_last_i,
  input  logic                          out_done_res_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [gme_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [gme_pkg::CFG_DAT_W-1:0] cfg_data_i,
  output int                            errors_o,
  output int                            pending_o
);
  import gme_pkg::*;

  logic [CFG_DAT_W-1:0] cfg_vars;
  logic [CFG_DAT_W-1:0] cfg_maxd;
  logic [2:0]           pos_list [15];
  logic [DEG_W-1:0]     cur_deg;
  logic                 deg_fresh;
  logic [IDX_W-1:0]     next_idx;
  logic                 run_done;

  result_t expected_monomials [$];
  int      mismatch_count = 0;
  int      result_count = 0;

  assign errors_o = mismatch_count;

  task automatic report_mismatch(input string msg);
    $display("%0t ERROR result %0d: %s", $time, result_count, msg);
    mismatch_count++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  task automatic predict_monomial(input logic restart, output result_t mono);
    int unsigned n;
    int unsigned top;
    int unsigned maxd;
    int unsigned cd;
    int unsigned p;
    int unsigned counts [16];
    int          j;
    int          k;
    logic        all_end;
    logic        is_last;
    logic        moved;
    mono = '0;
    n = (cfg_vars == 0) ? 1 : ((cfg_vars > MAX_VARS_DEF) ? MAX_VARS_DEF : cfg_vars);
    top = n - 1;
    maxd = cfg_maxd;
    if (restart || (next_idx == '0 && !run_done)) begin
      is_last = (maxd == 0);
      mono.last = is_last;
      next_idx = 19'd1;
      run_done = is_last;
      cur_deg = is_last ? 4'd0 : 4'd1;
      deg_fresh = 1'b1;
    end else if (run_done) begin
      mono.done_res = 1'b1;
    end else begin
      cd = (cur_deg == 0) ? 1 : cur_deg;
      if (deg_fresh) begin
        for (k = 0; k < cd; k++) pos_list[k] = '0;
        deg_fresh = 1'b0;
      end else begin
        for (k = 0; k < cd; k++) begin
          if (pos_list[k] > top) pos_list[k] = 3'(top);
        end
        if (pos_list[cd-1] == top) begin
          moved = 1'b0;
          for (j = int'(cd) - 2; j >= 0; j--) begin
            if (!moved && pos_list[j] < top) begin
              pos_list[j] = pos_list[j] + 3'd1;
              for (k = j + 1; k < cd; k++) pos_list[k] = pos_list[j];
              moved = 1'b1;
            end
          end
        end else begin
          pos_list[cd-1] = pos_list[cd-1] + 3'd1;
        end
      end
      for (k = 0; k < 16; k++) counts[k] = 0;
      all_end = 1'b1;
      for (k = 0; k < cd; k++) begin
        p = pos_list[k];
        if (p > top) p = top;
        counts[p]++;
        if (p != top) all_end = 1'b0;
      end
      for (k = 0; k < n; k++) mono.exponents[4*k +: 4] = 4'(counts[k]);
      is_last = all_end && (cd >= maxd);
      mono.total_degree = 4'(cd);
      mono.mono_index = next_idx;
      mono.last = is_last;
      next_idx = next_idx + 19'd1;
      cur_deg = 4'(cd);
      if (is_last) begin
        run_done = 1'b1;
      end else if (all_end) begin
        cur_deg = 4'(cd + 1);
        deg_fresh = 1'b1;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t mono;
    result_t seen;
    if (!rst_ni) begin
      cfg_vars = NUM_VARS_RST;
      cfg_maxd = MAX_DEGREE_RST;
      for (int k = 0; k < 15; k++) pos_list[k] = '0;
      cur_deg = '0;
      deg_fresh = 1'b1;
      next_idx = '0;
      run_done = 1'b0;
      expected_monomials.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_NUM_VARS: begin
            cfg_vars = cfg_data_i;
          end
          CFG_MAX_DEGREE: begin
            cfg_maxd = cfg_data_i;
          end
          default: begin
          end
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        predict_monomial(in_restart_i, mono);
        expected_monomials.push_back(mono);
      end
      if (out_valid_i && !out_stall_i) begin
        seen = '{exponents: out_exponents_i, total_degree: out_total_degree_i,
                 mono_index: out_mono_index_i, last: out_last_i,
                 done_res: out_done_res_i};
        if (expected_monomials.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected, mono_index %0d",
                                    seen.mono_index));
        end else begin
          mono = expected_monomials.pop_front();
          compare_field("exponents", seen.exponents, mono.exponents);
          compare_field("total_degree", 32'(seen.total_degree), 32'(mono.total_degree));
          compare_field("mono_index", 32'(seen.mono_index), 32'(mono.mono_index));
          compare_field("last", 32'(seen.last), 32'(mono.last));
          compare_field("done_res", 32'(seen.done_res), 32'(mono.done_res));
        end
        result_count++;
      end
      pending_o <= expected_monomials.size();
    end
  end

endmodule

// ===== test/tb_graded_monomial_enumerator.sv =====
`timescale 1ns / 100ps

module tb_graded_monomial_enumerator;
  import gme_pkg::*;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 in_restart_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [EXP_W-1:0]     out_exponents_o;
  logic [DEG_W-1:0]     out_total_degree_o;
  logic [IDX_W-1:0]     out_mono_index_o;
  logic                 out_last_o;
  logic                 out_done_res_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  cfg_idx_e             cfg_index_i;
  logic [CFG_DAT_W-1:0] cfg_data_i;

  int src_idle = 7;
  int sink_idle = 75;
  int mismatches;
  int pending;

  graded_monomial_enumerator i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .in_restart_i      (in_restart_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_exponents_o   (out_exponents_o),
    .out_total_degree_o(out_total_degree_o),
    .out_mono_index_o  (out_mono_index_o),
    .out_last_o        (out_last_o),
    .out_done_res_o    (out_done_res_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  monomial_checker i_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .in_restart_i      (in_restart_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_exponents_i   (out_exponents_o),
    .out_total_degree_i(out_total_degree_o),
    .out_mono_index_i  (out_mono_index_o),
    .out_last_i        (out_last_o),
    .out_done_res_i    (out_done_res_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_i       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .errors_o          (mismatches),
    .pending_o         (pending)
  );

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99, 0) < sink_idle);
  end

  task automatic send_req(input logic restart);
    @(negedge clk_i);
    while ($urandom_range(99, 0) < src_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    in_restart_i <= restart;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DAT_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int unsigned vars_w;
    int unsigned deg_w;
    int unsigned eff_vars;
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    in_restart_i <= 1'b0;
    out_stall_i  <= 1'b0;
    cfg_valid_i  <= 1'b0;
    cfg_index_i  <= CFG_NUM_VARS;
    cfg_data_i   <= '0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // advance before any restart, then a normal restart
    send_req(1'b0);
    send_req(1'b0);
    send_req(1'b1);
    send_req(1'b0);

    // zero vars and zero degree mid-run, then finished run
    wait_drained();
    write_reg(CFG_NUM_VARS, 4'd0);
    write_reg(CFG_MAX_DEGREE, 4'd0);
    send_req(1'b0);
    send_req(1'b1);
    send_req(1'b0);

    // vars above the maximum, degree one: walk to the end and past it
    wait_drained();
    write_reg(CFG_NUM_VARS, 4'd15);
    write_reg(CFG_MAX_DEGREE, 4'd1);
    send_req(1'b1);
    repeat (9) send_req(1'b0);

    // shrink vars in the middle of a degree
    wait_drained();
    write_reg(CFG_NUM_VARS, 4'd2);
    write_reg(CFG_MAX_DEGREE, 4'd3);
    send_req(1'b1);
    repeat (3) send_req(1'b0);
    wait_drained();
    write_reg(CFG_NUM_VARS, 4'd1);
    repeat (2) send_req(1'b0);

    for (int ph = 0; ph < 3; ph++) begin
      wait_drained();
      src_idle  = (ph == 0) ? 7 : ((ph == 1) ? 75 : 0);
      sink_idle = (ph == 0) ? 75 : ((ph == 1) ? 7 : 0);
      for (int seg = 0; seg < 7; seg++) begin
        wait_drained();
        vars_w = $urandom_range(15, 0);
        eff_vars = (vars_w == 0) ? 1 : ((vars_w > 8) ? 8 : vars_w);
        if (eff_vars <= 2 || $urandom_range(3, 0) == 0) begin
          deg_w = $urandom_range(15, 0);
        end else begin
          deg_w = $urandom_range(4, 0);
        end
        if ($urandom_range(5, 0) == 0) deg_w = 15;
        if (ph == 0 && seg == 0) begin
          vars_w = 8;
          deg_w  = 15;
        end
        if (ph == 0 && seg == 1) begin
          vars_w = 1;
          deg_w  = 15;
        end
        write_reg(CFG_NUM_VARS, 4'(vars_w));
        write_reg(CFG_MAX_DEGREE, 4'(deg_w));
        for (int k = 0; k < 50; k++) begin
          if (k == 25 && $urandom_range(2, 0) == 0) begin
            wait_drained();
            write_reg(cfg_idx_e'($urandom_range(1, 0)), 4'($urandom_range(15, 0)));
          end
          send_req((k == 0) || ($urandom_range(39, 0) == 0));
        end
      end
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS graded_monomial_enumerator");
    end else begin
      $display("FAIL graded_monomial_enumerator");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL graded_monomial_enumerator");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/gme_pkg.sv
rtl/gme_cfg.sv
rtl/gme_step.sv
rtl/graded_monomial_enumerator.sv
test/monomial_checker.sv
test/tb_graded_monomial_enumerator.sv
